/* design/range_max_sparse_table_assert.svh */
// ----------------------------------------------------------------------------
// Range-max sparse table: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SPARSE_TABLE_ASSERT_SVH
`define RANGE_MAX_SPARSE_TABLE_ASSERT_SVH

// same-cycle implication
`define RMST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rmst_pkg.sv */
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range-max sparse table.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int COUNT_BITS = 11;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int POS_BITS = 10;
    localparam int K_BITS = 4;
    localparam int IN_DATA_BITS = 64;
    localparam int OUT_DATA_BITS = 32;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_STALE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE        = 2'd0,
        S_BUILD_RUN   = 2'd1,
        S_BUILD_DRAIN = 2'd2
    } state_t;

endpackage

/* design/rmst_level_mem.sv */
// ----------------------------------------------------------------------------
// rmst_level_mem
// Level store of the sparse table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rmst_level_mem #(
    parameter int DATA_BITS = 32,
    parameter int ADDR_BITS = 14,
    parameter int DEPTH     = 11264
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr_a,
    input  logic [ADDR_BITS-1:0] raddr_b,
    output logic [DATA_BITS-1:0] rdata_a,
    output logic [DATA_BITS-1:0] rdata_b
);

    logic [DATA_BITS-1:0] mem [0:DEPTH-1];
    logic [DATA_BITS-1:0] rdata_a_reg;
    logic [DATA_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/range_max_sparse_table.sv */
// ----------------------------------------------------------------------------
// range_max_sparse_table
// Sparse-table range-maximum engine: element writes, table build, queries.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_*     | in  | tuser: action; tdata: elem_index, elem_value, range_low,
//          |     |        range_high
//  m_*     | out | tuser: status; tdata: max_value
//  cfg_*   | in  | cfg_wdata: element_count
//
//  A query result reaches the output register from the registered memory
//  read issued at its accept beat, once its stage can move on.
//  A build pauses intake while it fills each level k >= 1 from level k-1,
//  one entry per cycle through the two read ports of the level store.
//  Reset sets element_count to 1024 and marks the table not built; the level
//  store has no clearing pass. One beat waits in a stage while the output
//  register is stalled.
// ----------------------------------------------------------------------------
`include "range_max_sparse_table_assert.svh"

module range_max_sparse_table #(
    parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = rmst_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] elem_index, [41:10] elem_value, [51:42] range_low,
    // [61:52] range_high, [63:62] zero
    input  logic [rmst_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // [1:0] action
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] max_value
    output logic [rmst_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // [1:0] status
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [rmst_pkg::COUNT_BITS-1:0]    cfg_wdata
);

    import rmst_pkg::*;

    localparam int IDX_BITS  = $clog2(MAX_ELEMENTS);
    localparam int LEVELS    = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_BITS  = $clog2(LEVELS);
    localparam int ADDR_BITS = LVL_BITS + IDX_BITS;
    localparam int DEPTH     = LEVELS << IDX_BITS;
    localparam int IW        = ((IDX_BITS > COUNT_BITS) ? IDX_BITS : COUNT_BITS) + 1;

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic                    table_built_reg, table_built_next;
    logic [K_BITS-1:0]       lvl_reg, lvl_next;
    logic [IW-1:0]           j_reg, j_next;
    logic                    wr_pend_reg, wr_pend_next;
    logic [ADDR_BITS-1:0]    wr_addr_reg, wr_addr_next;
    logic                    stage_valid_reg, stage_valid_next;
    logic                    stage_cmp_reg;
    status_t                 stage_status_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    status_t                 m_tuser_reg;

    logic [POS_BITS-1:0]     elem_index;
    logic signed [31:0]      elem_value;
    logic [POS_BITS-1:0]     range_low;
    logic [POS_BITS-1:0]     range_high;

    logic                    s_accept;
    logic                    stage_move;
    logic [COUNT_BITS-1:0]   act_cnt;
    logic [IW-1:0]           act_w;
    logic [IW-1:0]           span_w;
    logic [IW-1:0]           half_w;
    logic [IW-1:0]           last_j;
    logic                    next_level;

    logic [COUNT_BITS-1:0]   q_len;
    logic [K_BITS-1:0]       q_k;
    logic [IW-1:0]           q_lo_w;
    logic [IW-1:0]           q_hi_w;
    logic [IW-1:0]           q_b_w;
    status_t                 q_status;

    logic                    mem_we;
    logic [ADDR_BITS-1:0]    mem_waddr;
    logic [VALUE_BITS-1:0]   mem_wdata;
    logic                    mem_re;
    logic [ADDR_BITS-1:0]    mem_raddr_a;
    logic [ADDR_BITS-1:0]    mem_raddr_b;
    logic signed [VALUE_BITS-1:0] rd_a;
    logic signed [VALUE_BITS-1:0] rd_b;
    logic signed [VALUE_BITS-1:0] rd_max;

    assign elem_index = s_tdata[9:0];
    assign elem_value = s_tdata[41:10];
    assign range_low  = s_tdata[51:42];
    assign range_high = s_tdata[61:52];

    assign stage_move = stage_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready   = (state_reg == S_IDLE) && (!stage_valid_reg || stage_move);
    assign s_accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (32'(count_reg) > 32'(MAX_ELEMENTS))
        begin
            act_cnt = COUNT_BITS'(MAX_ELEMENTS);
        end
        else
        begin
            act_cnt = count_reg;
        end
    end

    assign act_w      = IW'(act_cnt);
    assign span_w     = IW'(1) << lvl_reg;
    assign half_w     = span_w >> 1;
    assign last_j     = act_w - span_w;
    assign next_level = (span_w << 1) <= act_w;

    // query decode
    assign q_len  = COUNT_BITS'(range_high) - COUNT_BITS'(range_low) + COUNT_BITS'(1);
    assign q_lo_w = IW'(range_low);
    assign q_hi_w = IW'(range_high);
    assign q_b_w  = q_hi_w + IW'(1) - (IW'(1) << q_k);

    always_comb
    begin
        q_k = '0;
        for (int i = 0; i < COUNT_BITS; i++)
        begin
            if (q_len[i])
            begin
                q_k = K_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (range_high < range_low)
        begin
            q_status = STS_EMPTY;
        end
        else if (q_hi_w >= act_w)
        begin
            q_status = STS_RANGE;
        end
        else if (!table_built_reg)
        begin
            q_status = STS_STALE;
        end
        else
        begin
            q_status = STS_OK;
        end
    end

    assign rd_max = (rd_a >= rd_b) ? rd_a : rd_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_tuser == ACT_BUILD) && (act_cnt >= COUNT_BITS'(2)))
                begin
                    state_next = S_BUILD_RUN;
                end
            end
            S_BUILD_RUN:
            begin
                if (j_reg == last_j)
                begin
                    state_next = S_BUILD_DRAIN;
                end
            end
            S_BUILD_DRAIN:
            begin
                state_next = next_level ? S_BUILD_RUN : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        lvl_next         = lvl_reg;
        j_next           = j_reg;
        wr_pend_next     = 1'b0;
        wr_addr_next     = wr_addr_reg;
        table_built_next = table_built_reg;
        mem_re           = 1'b0;
        mem_raddr_a      = '0;
        mem_raddr_b      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (s_tuser)
                        ACT_WRITE:
                        begin
                            table_built_next = 1'b0;
                        end
                        ACT_BUILD:
                        begin
                            lvl_next = K_BITS'(1);
                            j_next   = '0;
                            if (act_cnt < COUNT_BITS'(2))
                            begin
                                table_built_next = 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (q_status == STS_OK)
                            begin
                                mem_re      = 1'b1;
                                mem_raddr_a = {LVL_BITS'(q_k), q_lo_w[IDX_BITS-1:0]};
                                mem_raddr_b = {LVL_BITS'(q_k), q_b_w[IDX_BITS-1:0]};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BUILD_RUN:
            begin
                mem_re       = 1'b1;
                mem_raddr_a  = {LVL_BITS'(lvl_reg - K_BITS'(1)), j_reg[IDX_BITS-1:0]};
                mem_raddr_b  = {LVL_BITS'(lvl_reg - K_BITS'(1)),
                                IDX_BITS'(j_reg + half_w)};
                wr_pend_next = 1'b1;
                wr_addr_next = {LVL_BITS'(lvl_reg), j_reg[IDX_BITS-1:0]};
                j_next       = j_reg + IW'(1);
            end
            S_BUILD_DRAIN:
            begin
                if (next_level)
                begin
                    lvl_next = lvl_reg + K_BITS'(1);
                    j_next   = '0;
                end
                else
                begin
                    table_built_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (cfg_we)
        begin
            table_built_next = 1'b0;
        end
    end

    // memory write: build pipeline or element write
    always_comb
    begin
        if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = rd_max;
        end
        else
        begin
            mem_we    = s_accept && (s_tuser == ACT_WRITE)
                        && (32'(elem_index) < 32'(MAX_ELEMENTS));
            mem_waddr = {{LVL_BITS{1'b0}}, IDX_BITS'(elem_index)};
            mem_wdata = VALUE_BITS'(elem_value);
        end
    end

    assign stage_valid_next = s_accept ? 1'b1 : (stage_move ? 1'b0 : stage_valid_reg);
    assign m_tvalid_next    = stage_move ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= COUNT_RESET;
            table_built_reg <= 1'b0;
            lvl_reg         <= '0;
            j_reg           <= '0;
            wr_pend_reg     <= 1'b0;
            stage_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            table_built_reg <= table_built_next;
            lvl_reg         <= lvl_next;
            j_reg           <= j_next;
            wr_pend_reg     <= wr_pend_next;
            stage_valid_reg <= stage_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        if (s_accept)
        begin
            stage_cmp_reg    <= (s_tuser == ACT_QUERY) && (q_status == STS_OK);
            stage_status_reg <= (s_tuser == ACT_QUERY) ? q_status : STS_OK;
        end
        if (stage_move)
        begin
            m_tdata_reg <= stage_cmp_reg ? OUT_DATA_BITS'(rd_max) : '0;
            m_tuser_reg <= stage_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    rmst_level_mem #(
        .DATA_BITS (VALUE_BITS),
        .ADDR_BITS (ADDR_BITS),
        .DEPTH     (DEPTH)
    ) u_level_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    `RMST_ASSERT_NOW(a_write_port_free, s_accept && (s_tuser == ACT_WRITE), !wr_pend_reg, "element write collides with build write")
    `RMST_ASSERT_NOW(a_drain_has_write, state_reg == S_BUILD_DRAIN, wr_pend_reg, "drain cycle without pending build write")
    `RMST_ASSERT_NEXT(a_build_marks_table, (state_reg == S_BUILD_DRAIN) && (state_next == S_IDLE), table_built_reg, "finished build left table stale")
    `RMST_ASSERT_NOW(a_query_on_built, stage_valid_reg && stage_cmp_reg, table_built_reg, "pending query read from stale table")

endmodule

/* test/range_max_sparse_table_test.sv */
// ----------------------------------------------------------------------------
// range_max_sparse_table_test
// Drives element writes, table builds and range-maximum queries into the
// sparse table and checks every result beat against a behavioral copy of
// the table held in a scoreboard. The element count is changed between
// phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module range_max_sparse_table_test;
    import rmst_pkg::*;

    localparam int ELEMS        = MAX_ELEMENTS_DEF;
    localparam int LEVELS       = 11;
    localparam int ITEM_TARGET  = 1450;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 3000000;

    class max_scoreboard;
        typedef struct packed {
            logic [31:0] max_value;
            status_t     status;
        } result_t;

        bit signed [31:0] levels [0:LEVELS-1][0:ELEMS-1];
        bit               built;
        int               count = COUNT_RESET;
        result_t          expected [$];
        int               mismatches;

        function void set_count(int value);
            count = value;
            built = 1'b0;
        endfunction

        function int active();
            return (count > ELEMS) ? ELEMS : count;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void build_levels();
            int cnt;
            cnt = active();
            for (int k = 1; k < LEVELS && (1 << k) <= cnt; k++)
                for (int j = 0; j + (1 << k) <= cnt; j++)
                    levels[k][j] = (levels[k-1][j] >= levels[k-1][j + (1 << (k-1))]) ?
                                   levels[k-1][j] : levels[k-1][j + (1 << (k-1))];
            built = 1'b1;
        endfunction

        function void note_input(action_t act, logic [9:0] idx, logic [31:0] val,
                                 logic [9:0] lo, logic [9:0] hi);
            result_t          want;
            int               lo_i;
            int               hi_i;
            int               span;
            int               k;
            bit signed [31:0] a;
            bit signed [31:0] b;
            want.max_value = '0;
            want.status = STS_OK;
            lo_i = lo;
            hi_i = hi;
            case (act)
                ACT_WRITE:
                begin
                    levels[0][idx] = val;
                    built = 1'b0;
                end
                ACT_BUILD:
                    build_levels();
                ACT_QUERY:
                begin
                    if (hi_i < lo_i)
                        want.status = STS_EMPTY;
                    else if (hi_i >= active())
                        want.status = STS_RANGE;
                    else if (!built)
                        want.status = STS_STALE;
                    else
                    begin
                        span = hi_i - lo_i + 1;
                        k = 0;
                        while ((2 << k) <= span)
                            k++;
                        a = levels[k][lo_i];
                        b = levels[k][hi_i + 1 - (1 << k)];
                        want.max_value = (a >= b) ? a : b;
                    end
                end
                default:
                    ;
            endcase
            expected.insert(expected.size(), want);
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] user);
            result_t want;
            if (expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: max %0d status %0d", $signed(data), user);
                return;
            end
            want = expected.pop_front();
            if (data !== want.max_value || user !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected max %0d status %0d, got max %0d status %0d",
                             $signed(want.max_value), want.status, $signed(data), user);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // [9:0] elem_index, [41:10] elem_value, [51:42] range_low,
    // [61:52] range_high, [63:62] zero
    logic [IN_DATA_BITS-1:0]  s_tdata;
    // [1:0] action
    logic [1:0]               s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    // [31:0] max_value
    logic [OUT_DATA_BITS-1:0] m_tdata;
    // [1:0] status
    logic [1:0]               m_tuser;
    logic                     cfg_we;
    logic [COUNT_BITS-1:0]    cfg_wdata;

    max_scoreboard sb = new;
    bit            written [0:ELEMS-1];
    bit            burst;
    bit            hold_output;
    int            settle_cycles;
    int            items_sent;
    int unsigned   cycle_count;

    range_max_sparse_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("range_max_sparse_table test failed");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(80, 30);
    endfunction

    function automatic int build_cycles(int cnt);
        int total;
        total = 0;
        for (int k = 1; (1 << k) <= cnt; k++)
            total += cnt - (1 << k) + 2;
        return total;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7, 0))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(16, 0) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit query_safe(int lo, int hi);
        if (hi < lo || hi >= sb.active() || !sb.built)
            return 1'b1;
        for (int i = lo; i <= hi; i++)
            if (!written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_beat(action_t act, logic [9:0] idx, logic [31:0] val,
                             logic [9:0] lo, logic [9:0] hi);
        int gap;
        gap = burst ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, hi, lo, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(act, idx, val, lo, hi);
        items_sent++;
    endtask

    task automatic write_elem(int idx, logic [31:0] val);
        send_beat(ACT_WRITE, POS_BITS'(idx), val, POS_BITS'($urandom), POS_BITS'($urandom));
        written[idx] = 1'b1;
    endtask

    task automatic query(int lo, int hi);
        send_beat(ACT_QUERY, POS_BITS'($urandom), $urandom, POS_BITS'(lo), POS_BITS'(hi));
    endtask

    task automatic build_table();
        send_beat(ACT_BUILD, POS_BITS'($urandom), $urandom, POS_BITS'($urandom),
                  POS_BITS'($urandom));
        settle_cycles = build_cycles(sb.active());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic set_element_count(int value);
        drain_results();
        repeat (settle_cycles + 4) @(posedge clk);
        settle_cycles = 0;
        cfg_we    <= 1'b1;
        cfg_wdata <= value[COUNT_BITS-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_count(value);
    endtask

    task automatic random_query(int wlo, int whi);
        int lo;
        int hi;
        int r;
        r = $urandom_range(9, 0);
        if (r <= 5)
        begin
            lo = $urandom_range(whi, wlo);
            hi = $urandom_range(whi, lo);
        end
        else if (r == 6)
        begin
            lo = $urandom_range(ELEMS - 1, 1);
            hi = $urandom_range(lo - 1, 0);
        end
        else if (r == 7 && sb.active() < ELEMS)
        begin
            hi = $urandom_range(ELEMS - 1, sb.active());
            lo = $urandom_range(hi, 0);
        end
        else
        begin
            lo = $urandom_range(ELEMS - 1, 0);
            hi = $urandom_range(ELEMS - 1, 0);
            if (!query_safe(lo, hi))
            begin
                lo = $urandom_range(whi, wlo);
                hi = $urandom_range(whi, lo);
            end
        end
        query(lo, hi);
    endtask

    task automatic random_phase(bit squeeze);
        int cnt;
        int act_cnt;
        int wlen;
        int wlo;
        int whi;
        int r;
        r = $urandom_range(11, 0);
        if (r <= 6)
            cnt = $urandom_range(64, 1);
        else if (r <= 8)
            cnt = $urandom_range(ELEMS, 65);
        else if (r == 9)
            cnt = ELEMS;
        else if (r == 10)
            cnt = 1;
        else
            cnt = $urandom_range(1, 0) ? 0 : $urandom_range(2047, ELEMS + 1);
        set_element_count(cnt);
        act_cnt = sb.active();
        burst = ($urandom_range(3, 0) == 0);
        if (act_cnt == 0)
        begin
            repeat (4) query($urandom_range(ELEMS - 1, 0), $urandom_range(ELEMS - 1, 0));
            build_table();
            query(0, 0);
            return;
        end
        wlen = $urandom_range((act_cnt < 48) ? act_cnt : 48, 1);
        wlo  = $urandom_range(act_cnt - wlen, 0);
        whi  = wlo + wlen - 1;
        for (int i = wlo; i <= whi; i++)
            write_elem(i, pick_value());
        if ($urandom_range(2, 0) == 0)
            random_query(wlo, whi);
        build_table();
        if (squeeze)
        begin
            hold_output = 1'b1;
            burst = 1'b1;
        end
        repeat ($urandom_range(40, 15))
        begin
            r = $urandom_range(29, 0);
            if (r == 0)
                write_elem($urandom_range(ELEMS - 1, 0), pick_value());
            else if (r == 1)
                write_elem($urandom_range(whi, wlo), pick_value());
            else if (r <= 3)
                build_table();
            else if (r == 4 && !squeeze)
                drain_results();
            else
                random_query(wlo, whi);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int mode_left;
        bit steady;
        stall_left = 0;
        mode_left = 0;
        steady = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (hold_output)
            begin
                hold_output = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                steady = ($urandom_range(3, 0) == 0);
                mode_left = $urandom_range(200, 30);
            end
            mode_left--;
            if (stall_left == 0 && !steady)
                stall_left = idle_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int phase;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_WRITE;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        query(0, 0);
        query(ELEMS - 1, 0);
        write_elem(0, 32'h8000_0000);
        write_elem(1, 32'h7fff_ffff);
        write_elem(2, 32'hffff_ffff);
        write_elem(3, 32'h0000_0000);
        write_elem(ELEMS - 1, 32'h5555_5555);
        write_elem(ELEMS - 2, 32'haaaa_aaaa);
        write_elem(ELEMS - 3, 32'h0000_1234);
        query(0, 3);
        build_table();
        query(0, 0);
        query(0, 3);
        query(2, 3);
        query(ELEMS - 3, ELEMS - 1);
        query(ELEMS - 1, ELEMS - 1);

        set_element_count(0);
        query(0, 0);
        build_table();
        query(0, 0);

        set_element_count(2047);
        query(ELEMS - 3, ELEMS - 1);
        build_table();
        query(ELEMS - 2, ELEMS - 1);

        set_element_count(1);
        build_table();
        query(0, 0);
        query(0, 1);
        write_elem(0, 32'hffff_fffb);
        query(0, 0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            random_phase(phase == 1);
            phase++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle_cycles + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("range_max_sparse_table test passed");
        else
            $display("range_max_sparse_table test failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/rmst_pkg.sv
design/rmst_level_mem.sv
design/range_max_sparse_table.sv
test/range_max_sparse_table_test.sv
